// ===== hw/rtl/scgc_pkg.sv =====
package scgc_pkg;

	localparam int CharW  = 8;
	localparam int CountW = 6;
	localparam logic [CountW-1:0] CountMax = '1;

	// commands from the controller to the cell chain
	typedef struct packed {
		logic insert;   // count or insert char_byte
		logic drop;     // byte arrived at full capacity
		logic drain;    // shift the chain one cell toward the head
		logic clear;    // end of block: reset item count and drop flag
	} cmd_t;

	// status from the cell chain to the controller
	typedef struct packed {
		logic full;       // capacity for this block used up
		logic head_valid; // cell 0 holds a group
		logic next_valid; // cell 1 holds a group
	} sts_t;

endpackage

// ===== hw/rtl/scgc_ctrl.sv =====
module scgc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          last_char,
	input  scgc_pkg::sts_t sts,
	output scgc_pkg::cmd_t cmd,
	output logic          busy,
	output logic          strobe,
	output logic          last_group
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		cmd.insert = accept && !sts.full;
		cmd.drop   = accept && sts.full;
		cmd.drain  = (state_q == ST_EMIT);
		cmd.clear  = (state_q == ST_EMIT) && (!sts.head_valid || !sts.next_valid);
	end

	assign strobe     = (state_q == ST_EMIT) && sts.head_valid;
	assign last_group = !sts.next_valid;
	assign busy       = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && last_char) begin
						state_q <= ST_EMIT;
						busy_q  <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (cmd.clear) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/scgc_cells.sv =====
module scgc_cells #(
	parameter int MAX_ITEMS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  scgc_pkg::cmd_t                cmd,
	input  logic [scgc_pkg::CharW-1:0]    char_byte,
	output scgc_pkg::sts_t                sts,
	output logic [scgc_pkg::CharW-1:0]    head_char,
	output logic [scgc_pkg::CountW-1:0]   head_count,
	output logic                          dropped
);

	localparam int ItemW = $clog2(MAX_ITEMS + 1);

	logic [scgc_pkg::CharW-1:0]  val_q [MAX_ITEMS];
	logic [scgc_pkg::CountW-1:0] cnt_q [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]        vld_q;

	logic [MAX_ITEMS-1:0] lt;       // cell holds a smaller value
	logic [MAX_ITEMS-1:0] eq;       // cell holds this value
	logic [MAX_ITEMS-1:0] lt_prev;  // neighbor toward the head is smaller
	logic                 hit;

	logic [ItemW-1:0] items_q;
	logic             dropped_q;

	// neighbor toward the tail, for draining
	logic [scgc_pkg::CharW-1:0]  nxt_val [MAX_ITEMS];
	logic [scgc_pkg::CountW-1:0] nxt_cnt [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]        nxt_vld;
	// neighbor toward the head, for inserting
	logic [scgc_pkg::CharW-1:0]  prv_val [MAX_ITEMS];
	logic [scgc_pkg::CountW-1:0] prv_cnt [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]        prv_vld;

	assign hit = |eq;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		assign lt[i] = vld_q[i] && (val_q[i] < char_byte);
		assign eq[i] = vld_q[i] && (val_q[i] == char_byte);

		if (i == 0) begin : g_head
			assign lt_prev[i] = 1'b1;
			assign prv_val[i] = val_q[i];
			assign prv_cnt[i] = cnt_q[i];
			assign prv_vld[i] = 1'b0;
		end else begin : g_body
			assign lt_prev[i] = lt[i-1];
			assign prv_val[i] = val_q[i-1];
			assign prv_cnt[i] = cnt_q[i-1];
			assign prv_vld[i] = vld_q[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign nxt_val[i] = val_q[i];
			assign nxt_cnt[i] = cnt_q[i];
			assign nxt_vld[i] = 1'b0;
		end else begin : g_mid
			assign nxt_val[i] = val_q[i+1];
			assign nxt_cnt[i] = cnt_q[i+1];
			assign nxt_vld[i] = vld_q[i+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (cmd.drain) begin
				vld_q[i] <= nxt_vld[i];
			end else if (cmd.insert && !hit && !lt[i]) begin
				vld_q[i] <= lt_prev[i] ? 1'b1 : prv_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.drain) begin
				val_q[i] <= nxt_val[i];
				cnt_q[i] <= nxt_cnt[i];
			end else if (cmd.insert) begin
				if (hit) begin
					if (eq[i] && (cnt_q[i] != scgc_pkg::CountMax)) begin
						cnt_q[i] <= cnt_q[i] + 1'b1;
					end
				end else if (!lt[i]) begin
					if (lt_prev[i]) begin
						val_q[i] <= char_byte;
						cnt_q[i] <= scgc_pkg::CountW'(1);
					end else begin
						val_q[i] <= prv_val[i];
						cnt_q[i] <= prv_cnt[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q   <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.clear) begin
			items_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.insert) begin
				items_q <= items_q + 1'b1;
			end
			if (cmd.drop) begin
				dropped_q <= 1'b1;
			end
		end
	end

	always_comb begin
		sts.full       = (items_q == ItemW'(MAX_ITEMS));
		sts.head_valid = vld_q[0];
		sts.next_valid = nxt_vld[0];
	end

	assign head_char  = val_q[0];
	assign head_count = cnt_q[0];
	assign dropped    = dropped_q;

endmodule

// ===== hw/rtl/sorted_character_group_count_unit.sv =====
// Sorted character histogram.
//
// Input: drive char_byte and last_char with start high. The byte transfers at
// the rising edge where start is high and busy is low. Bytes sit in a sorted
// chain of MAX_ITEMS cells; each transfer counts or inserts its byte in that
// same cycle, so one byte per cycle is taken while busy is low.
// Bytes beyond MAX_ITEMS in one block are dropped and mark the block overflowed.
//
// Output: the cycle after the byte marked last_char, busy rises and the chain
// drains from its head, one group per cycle, in ascending byte order. Each
// group is valid for exactly one cycle with strobe high; last_group marks the
// final one and overflow is set on every group of an overflowed block. The
// receiver cannot stall, so a block of G distinct bytes (at most MAX_ITEMS)
// holds busy until its last group has drained from the head of the chain.
// Busy falls after the last group, ready for the next block.
//
// Reset (arst_n low, asynchronous) empties the chain and clears the item count
// and the overflow flag; no clearing pass is needed.
module sorted_character_group_count_unit #(
	parameter int MAX_ITEMS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [scgc_pkg::CharW-1:0]  char_byte,
	input  logic                        last_char,
	output logic                        strobe,
	output logic [scgc_pkg::CharW-1:0]  group_char,
	output logic [scgc_pkg::CountW-1:0] group_count,
	output logic                        last_group,
	output logic                        overflow
);

	scgc_pkg::cmd_t cmd;
	scgc_pkg::sts_t sts;

	// controller: accept transfers, sequence the drain
	scgc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_char  (last_char),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy),
		.strobe     (strobe),
		.last_group (last_group)
	);

	// datapath: sorted cell chain plus item counter and drop flag
	scgc_cells #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_cells (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.char_byte  (char_byte),
		.sts        (sts),
		.head_char  (group_char),
		.head_count (group_count),
		.dropped    (overflow)
	);

	// results only appear while the input side is held off
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result strobe while not busy");

	// groups of a block come out back to back
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_group |=> strobe)
		else $error("gap inside a group stream");

	// groups come out in strictly ascending byte order
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_group |=> group_char > $past(group_char))
		else $error("groups out of order");

	// the final group releases the input side
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_group |=> !busy)
		else $error("busy held after final group");

	// a transfer marked last starts the drain
	a_start_drain: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_char |=> busy && strobe)
		else $error("drain did not start after last byte");

endmodule
